@@ sv/uqpd_pkg.sv @@
// Shared types, character codes and helper functions for the query pair decoder.
// No dependencies; every other file in this folder refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package uqpd_pkg;

    localparam logic [7:0] CH_PERCENT  = 8'd37;
    localparam logic [7:0] CH_AMP      = 8'd38;
    localparam logic [7:0] CH_EQ       = 8'd61;
    localparam logic [7:0] CH_QMARK    = 8'd63;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] NIBBLE_MASK = 8'h0f;

    localparam int QUEUE_DEPTH = 2;

    // Escape progress of the front end
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_state_t;

    // Classification of one input byte against the current state
    typedef enum logic [2:0] {
        CLS_KEY_END  = 3'd0,
        CLS_PAIR_END = 3'd1,
        CLS_HIGH     = 3'd2,
        CLS_LOW      = 3'd3,
        CLS_DROP     = 3'd4,
        CLS_CUT      = 3'd5,
        CLS_PERCENT  = 3'd6,
        CLS_LITERAL  = 3'd7
    } cls_t;

    // What the back end has to do with a queued command
    typedef enum logic [1:0] {
        OP_MARK    = 2'd0,
        OP_LITERAL = 2'd1,
        OP_ESCAPE  = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] byte_a;     // literal byte, or high escape digit
        logic [7:0] byte_b;     // low escape digit
        logic       is_value;
        logic       key_end;
        logic       pair_end;
        logic       stream_end;
    } cmd_t;

    // Hex-ish digit value without validity check: 0..24
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] base;
        logic [7:0] low;
        begin
            base = (c <= CH_NINE) ? 5'd0 : 5'd9;
            low  = c & NIBBLE_MASK;
            digit_value = base + low[4:0];
        end
    endfunction

    // ((d(hi) << 4) + d(lo)) mod 256
    function automatic logic [7:0] escape_byte(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] dh;
        logic [4:0] dl;
        begin
            dh = digit_value(hi);
            dl = digit_value(lo);
            escape_byte = {dh[3:0], 4'b0000} + {3'b000, dl};
        end
    endfunction

endpackage

`default_nettype wire

@@ sv/url_query_pair_decoder_core.sv @@
// URL query string pair decoder, top level: front end, command queue, back end.
// Depends on uqpd_pkg, uqpd_front, uqpd_queue and uqpd_back.
//
// Usage:
//   Input channel (s_valid/s_ready): one raw query string byte per transfer,
//   s_last marks the final byte. Result channel (m_valid/m_ready): at most one
//   result per input byte: a decoded byte (m_has_byte) tagged key or value,
//   and/or key_end, pair_end and stream_end markers. Bytes that produce nothing
//   ('%', the high escape digit, '?', dropped bytes) are absorbed silently.
//   Path: a result's command is written into the queue on its input transfer
//   and then taken by the output register, which drives m_valid.
//   Throughput: one byte per cycle while s_ready is high, set by the front
//   end state update; results drain at one per cycle while m_ready is high.
//   Stall: when m_ready is low the output register holds its result, the
//   queue fills (QUEUE_DEPTH entries) and s_ready then drops until space frees.
//   Reset (aresetn low, synchronous): parse state returns to key side, no
//   escape, no cut; the queue and output register are emptied. After the byte
//   marked last the parse state returns to the same values.
`timescale 1ns / 1ps
`default_nettype none

module url_query_pair_decoder_core #(
    parameter int QUEUE_DEPTH = uqpd_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_in,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte_out,
    output logic             m_has_byte,
    output logic             m_is_value,
    output logic             m_key_end,
    output logic             m_pair_end,
    output logic             m_stream_end
);

    uqpd_pkg::cmd_t  front_cmd;
    uqpd_pkg::cmd_t  head_cmd;
    logic            front_emit;
    logic            accept;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;

    // Take a byte whenever the queue has a free slot
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    uqpd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .byte_in (s_byte_in),
        .last    (s_last),
        .cmd     (front_cmd),
        .emit    (front_emit)
    );

    // Queue only bytes that produce a result
    uqpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && front_emit),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    uqpd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_not_empty),
        .cmd          (head_cmd),
        .cmd_pop      (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_out   (m_byte_out),
        .m_has_byte   (m_has_byte),
        .m_is_value   (m_is_value),
        .m_key_end    (m_key_end),
        .m_pair_end   (m_pair_end),
        .m_stream_end (m_stream_end)
    );

endmodule

`default_nettype wire

@@ sv/uqpd_front.sv @@
// Front end: classifies each input byte, tracks key/value, escape and cut state,
// and produces one command per result. Depends on uqpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uqpd_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     byte_in,
    input  wire logic           last,
    output uqpd_pkg::cmd_t      cmd,
    output logic                emit
);

    logic                  in_value_reg, in_value_next;
    logic                  token_cut_reg, token_cut_next;
    logic [7:0]            high_digit_reg, high_digit_next;
    uqpd_pkg::esc_state_t  esc_reg, esc_next;
    uqpd_pkg::cls_t        cls;

    // Classify: order decides
    always_comb begin
        priority if (byte_in == uqpd_pkg::CH_EQ && !in_value_reg) begin
            cls = uqpd_pkg::CLS_KEY_END;
        end else if (byte_in == uqpd_pkg::CH_AMP && in_value_reg) begin
            cls = uqpd_pkg::CLS_PAIR_END;
        end else if (esc_reg == uqpd_pkg::ESC_HIGH) begin
            cls = uqpd_pkg::CLS_HIGH;
        end else if (esc_reg == uqpd_pkg::ESC_LOW) begin
            cls = uqpd_pkg::CLS_LOW;
        end else if (token_cut_reg) begin
            cls = uqpd_pkg::CLS_DROP;
        end else if (byte_in == uqpd_pkg::CH_QMARK) begin
            cls = uqpd_pkg::CLS_CUT;
        end else if (byte_in == uqpd_pkg::CH_PERCENT) begin
            cls = uqpd_pkg::CLS_PERCENT;
        end else begin
            cls = uqpd_pkg::CLS_LITERAL;
        end
    end

    // Next state
    always_comb begin
        in_value_next   = in_value_reg;
        token_cut_next  = token_cut_reg;
        high_digit_next = high_digit_reg;
        esc_next        = esc_reg;
        unique case (cls)
            uqpd_pkg::CLS_KEY_END: begin
                in_value_next  = 1'b1;
                esc_next       = uqpd_pkg::ESC_NONE;
                token_cut_next = 1'b0;
            end
            uqpd_pkg::CLS_PAIR_END: begin
                in_value_next  = 1'b0;
                esc_next       = uqpd_pkg::ESC_NONE;
                token_cut_next = 1'b0;
            end
            uqpd_pkg::CLS_HIGH: begin
                high_digit_next = byte_in;
                esc_next        = uqpd_pkg::ESC_LOW;
            end
            uqpd_pkg::CLS_LOW:     esc_next       = uqpd_pkg::ESC_NONE;
            uqpd_pkg::CLS_CUT:     token_cut_next = 1'b1;
            uqpd_pkg::CLS_PERCENT: esc_next       = uqpd_pkg::ESC_HIGH;
            uqpd_pkg::CLS_DROP, uqpd_pkg::CLS_LITERAL: begin
            end
            default: begin
            end
        endcase
        // End of string: start over
        if (last) begin
            in_value_next   = 1'b0;
            token_cut_next  = 1'b0;
            high_digit_next = 8'd0;
            esc_next        = uqpd_pkg::ESC_NONE;
        end
    end

    // Outputs
    always_comb begin
        logic has;
        has            = 1'b0;
        cmd.op         = uqpd_pkg::OP_MARK;
        cmd.byte_a     = byte_in;
        cmd.byte_b     = byte_in;
        cmd.is_value   = in_value_reg;
        cmd.key_end    = 1'b0;
        cmd.pair_end   = 1'b0;
        cmd.stream_end = last;
        unique case (cls)
            uqpd_pkg::CLS_KEY_END: begin
                cmd.key_end  = 1'b1;
                cmd.is_value = 1'b0;
            end
            uqpd_pkg::CLS_PAIR_END: begin
                cmd.pair_end = 1'b1;
                cmd.is_value = 1'b1;
            end
            uqpd_pkg::CLS_LOW: begin
                cmd.op     = uqpd_pkg::OP_ESCAPE;
                cmd.byte_a = high_digit_reg;
                has        = 1'b1;
            end
            uqpd_pkg::CLS_LITERAL: begin
                cmd.op = uqpd_pkg::OP_LITERAL;
                has    = 1'b1;
            end
            uqpd_pkg::CLS_HIGH, uqpd_pkg::CLS_DROP, uqpd_pkg::CLS_CUT,
            uqpd_pkg::CLS_PERCENT: begin
            end
            default: begin
            end
        endcase
        // Input end closes the pair; tag with the side reached after this byte
        if (last && !cmd.pair_end) begin
            cmd.pair_end = 1'b1;
            cmd.is_value = (cls == uqpd_pkg::CLS_KEY_END) ? 1'b1 : in_value_reg;
        end
        emit = has | cmd.key_end | cmd.pair_end | last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_reg   <= 1'b0;
            token_cut_reg  <= 1'b0;
            high_digit_reg <= 8'd0;
            esc_reg        <= uqpd_pkg::ESC_NONE;
        end else if (accept) begin
            in_value_reg   <= in_value_next;
            token_cut_reg  <= token_cut_next;
            high_digit_reg <= high_digit_next;
            esc_reg        <= esc_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/uqpd_queue.sv @@
// Short command queue between front and back end.
// Depends on uqpd_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module uqpd_queue #(
    parameter int DEPTH = uqpd_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire uqpd_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output uqpd_pkg::cmd_t      head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    uqpd_pkg::cmd_t  mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/uqpd_back.sv @@
// Back end: decodes queued commands into result fields and holds them in the
// output register until transferred. Depends on uqpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uqpd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_valid,
    input  wire uqpd_pkg::cmd_t cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_byte_out,
    output logic                m_has_byte,
    output logic                m_is_value,
    output logic                m_key_end,
    output logic                m_pair_end,
    output logic                m_stream_end
);

    logic        valid_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        has_reg, has_next;
    logic        is_value_reg, key_end_reg, pair_end_reg, stream_end_reg;

    assign cmd_pop = cmd_valid && (!valid_reg || m_ready);

    always_comb begin
        unique case (cmd.op)
            uqpd_pkg::OP_LITERAL: begin
                byte_next = cmd.byte_a;
                has_next  = 1'b1;
            end
            uqpd_pkg::OP_ESCAPE: begin
                byte_next = uqpd_pkg::escape_byte(cmd.byte_a, cmd.byte_b);
                has_next  = 1'b1;
            end
            default: begin
                byte_next = 8'd0;
                has_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            byte_reg       <= byte_next;
            has_reg        <= has_next;
            is_value_reg   <= cmd.is_value;
            key_end_reg    <= cmd.key_end;
            pair_end_reg   <= cmd.pair_end;
            stream_end_reg <= cmd.stream_end;
        end
    end

    assign m_valid      = valid_reg;
    assign m_byte_out   = byte_reg;
    assign m_has_byte   = has_reg;
    assign m_is_value   = is_value_reg;
    assign m_key_end    = key_end_reg;
    assign m_pair_end   = pair_end_reg;
    assign m_stream_end = stream_end_reg;

endmodule

`default_nettype wire
